FILE: design/cpa_pkg.sv
// Shared constants, types and helper functions for the complex pixel arithmetic unit.
package cpa_pkg;

    localparam int OUT_W            = 20;
    localparam int ANG_W            = 34;
    localparam int REM_W            = 36;
    localparam int GUARD_BITS       = 8;
    localparam int X_EXTRA          = 11;
    localparam int RECIP_SHIFT      = 48;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_IN_WIDTH     = 16;

    localparam logic [1:0] MODE_MUL   = 2'd0;
    localparam logic [1:0] MODE_CONJ  = 2'd1;
    localparam logic [1:0] MODE_POLAR = 2'd2;
    localparam logic [1:0] MODE_CART  = 2'd3;

    localparam logic REG_OP_MODE = 1'b0;

    // Angles in radians, Q30
    localparam logic signed [REM_W-1:0] ANG_PI         = 36'sd3373259426;
    localparam logic signed [REM_W-1:0] ANG_HALF_PI    = 36'sd1686629713;
    localparam logic signed [REM_W-1:0] ANG_TWO_PI     = 36'sd6746518852;
    localparam logic signed [REM_W-1:0] ANG_THREE_HALF = 36'sd5059889139;

    // 2^36 / (2*pi): reciprocal of 2*pi in Q12 units, scaled by 2^48
    localparam logic signed [34:0] RECIP_TWO_PI = 35'sd10937044079;
    // CORDIC gain compensation, Q22
    localparam logic signed [22:0] GAIN_Q22     = 23'sd2547003;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0] mode;
        logic       aux;    // zero vector (polar) or result flip (cartesian)
    } cpa_ctl_t;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return $signed(ANG_W'(v));
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > 64'(OUT_MAX))
            r = OUT_MAX;
        else if (v < 64'(OUT_MIN))
            r = OUT_MIN;
        else
            r = OUT_W'(v);
        return r;
    endfunction

endpackage

FILE: design/cpa_pre.sv
// Front pipeline: products, angle reduction and CORDIC start values.
module cpa_pre #(
    parameter int IN_WIDTH = cpa_pkg::DEF_IN_WIDTH,
    parameter int XW       = IN_WIDTH + cpa_pkg::X_EXTRA
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [1:0]                      mode,
    input  logic                            in_v,
    output logic                            in_rdy,
    input  logic signed [IN_WIDTH-1:0]      a_first,
    input  logic signed [IN_WIDTH-1:0]      a_second,
    input  logic signed [IN_WIDTH-1:0]      b_real,
    input  logic signed [IN_WIDTH-1:0]      b_imag,
    output logic                            out_v,
    input  logic                            out_rdy,
    output cpa_pkg::cpa_ctl_t               out_ctl,
    output logic signed [XW-1:0]            out_x,
    output logic signed [XW-1:0]            out_y,
    output logic signed [cpa_pkg::ANG_W-1:0] out_z
);
    import cpa_pkg::*;

    localparam int W  = IN_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int TW = W + 35;
    localparam int RW = W + 23;
    localparam int MW = W + 36;

    logic adv1, adv2, adv3, adv4;

    // stage 1
    logic                 s1_v_reg;
    logic [1:0]           s1_mode_reg;
    logic signed [W-1:0]  s1_a0_reg, s1_a1_reg;
    logic signed [PW-1:0] s1_p0_reg, s1_p1_reg, s1_p2_reg, s1_p3_reg;
    logic signed [TW-1:0] s1_pt_reg;
    logic signed [RW-1:0] s1_pr_reg;
    logic signed [PW-1:0] s1_p0_next, s1_p1_next, s1_p2_next, s1_p3_next;
    logic signed [TW-1:0] s1_pt_next;
    logic signed [RW-1:0] s1_pr_next;

    // stage 2
    logic                    s2_v_reg;
    cpa_ctl_t                s2_ctl_reg, s2_ctl_next;
    logic signed [XW-1:0]    s2_x_reg, s2_y_reg, s2_x_next, s2_y_next;
    logic signed [REM_W-1:0] s2_z_reg, s2_z_next;
    logic signed [SW-1:0]    s2_s0_reg, s2_s1_reg, s2_s0_next, s2_s1_next;
    logic signed [W-1:0]     q_est;
    logic signed [MW-1:0]    t_full, q_prod;
    logic signed [RW-1:0]    x_rot;
    logic signed [XW-1:0]    ax, ay;

    // stage 3
    logic                    s3_v_reg;
    cpa_ctl_t                s3_ctl_reg, s3_ctl_next;
    logic signed [XW-1:0]    s3_x_reg, s3_y_reg, s3_x_next, s3_y_next;
    logic signed [REM_W-1:0] s3_z_reg, s3_z_next;
    logic signed [SW-1:0]    r0, r1;
    logic signed [XW-1:0]    neg_y;

    // stage 4
    logic                    s4_v_reg;
    cpa_ctl_t                s4_ctl_reg, s4_ctl_next;
    logic signed [XW-1:0]    s4_x_reg, s4_y_reg;
    logic signed [ANG_W-1:0] s4_z_reg, s4_z_next;

    assign adv4   = !s4_v_reg || out_rdy;
    assign adv3   = !s3_v_reg || adv4;
    assign adv2   = !s2_v_reg || adv3;
    assign adv1   = !s1_v_reg || adv2;
    assign in_rdy = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            if (adv1) s1_v_reg <= in_v;
            if (adv2) s2_v_reg <= s1_v_reg;
            if (adv3) s3_v_reg <= s2_v_reg;
            if (adv4) s4_v_reg <= s3_v_reg;
        end
    end

    // stage 1: products of the inputs
    assign s1_p0_next = PW'(a_first) * PW'(b_real);
    assign s1_p1_next = PW'(a_second) * PW'(b_imag);
    assign s1_p2_next = PW'(a_first) * PW'(b_imag);
    assign s1_p3_next = PW'(a_second) * PW'(b_real);
    assign s1_pt_next = TW'(a_second) * TW'(RECIP_TWO_PI);
    assign s1_pr_next = RW'(a_first) * RW'(GAIN_Q22);

    always_ff @(posedge clk)
    begin
        if (adv1 && in_v)
        begin
            s1_mode_reg <= mode;
            s1_a0_reg   <= a_first;
            s1_a1_reg   <= a_second;
            s1_p0_reg   <= s1_p0_next;
            s1_p1_reg   <= s1_p1_next;
            s1_p2_reg   <= s1_p2_next;
            s1_p3_reg   <= s1_p3_next;
            s1_pt_reg   <= s1_pt_next;
            s1_pr_reg   <= s1_pr_next;
        end
    end

    // stage 2: sums, first remainder, start vectors
    always_comb
    begin
        s2_s0_next = SW'(s1_p0_reg) - SW'(s1_p1_reg);
        s2_s1_next = SW'(s1_p2_reg) + SW'(s1_p3_reg);
        q_est      = W'(s1_pt_reg >>> RECIP_SHIFT);
        t_full     = MW'(s1_a1_reg) <<< 18;
        q_prod     = MW'(q_est) * MW'(ANG_TWO_PI);
        x_rot      = (s1_pr_reg + RW'(8192)) >>> 14;
        ax         = XW'(s1_a0_reg) <<< 8;
        ay         = XW'(s1_a1_reg) <<< 8;
        s2_ctl_next.mode = s1_mode_reg;
        s2_ctl_next.aux  = 1'b0;
        s2_x_next  = XW'(s1_a0_reg);
        s2_y_next  = XW'(s1_a1_reg);
        s2_z_next  = '0;
        unique case (s1_mode_reg)
            MODE_MUL, MODE_CONJ:
            begin
                s2_x_next = XW'(s1_a0_reg);
                s2_y_next = XW'(s1_a1_reg);
            end
            MODE_POLAR:
            begin
                s2_ctl_next.aux = (s1_a0_reg == '0) && (s1_a1_reg == '0);
                if (s1_a0_reg[W-1])
                begin
                    s2_x_next = -ax;
                    s2_y_next = -ay;
                    s2_z_next = s1_a1_reg[W-1] ? -ANG_PI : ANG_PI;
                end
                else
                begin
                    s2_x_next = ax;
                    s2_y_next = ay;
                end
            end
            MODE_CART:
            begin
                s2_x_next = XW'(x_rot);
                s2_y_next = '0;
                s2_z_next = REM_W'(t_full - q_prod);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_v_reg)
        begin
            s2_ctl_reg <= s2_ctl_next;
            s2_x_reg   <= s2_x_next;
            s2_y_reg   <= s2_y_next;
            s2_z_reg   <= s2_z_next;
            s2_s0_reg  <= s2_s0_next;
            s2_s1_reg  <= s2_s1_next;
        end
    end

    // stage 3: round products, conjugate, correct the remainder into [0, 2pi)
    always_comb
    begin
        r0          = (s2_s0_reg + SW'(2048)) >>> 12;
        r1          = (s2_s1_reg + SW'(2048)) >>> 12;
        neg_y       = -s2_y_reg;
        s3_ctl_next = s2_ctl_reg;
        s3_x_next   = s2_x_reg;
        s3_y_next   = s2_y_reg;
        s3_z_next   = s2_z_reg;
        unique case (s2_ctl_reg.mode)
            MODE_MUL:
            begin
                s3_x_next = XW'(sat_out(64'(r0)));
                s3_y_next = XW'(sat_out(64'(r1)));
            end
            MODE_CONJ:
            begin
                s3_x_next = XW'(sat_out(64'(s2_x_reg)));
                s3_y_next = XW'(sat_out(64'(neg_y)));
            end
            MODE_POLAR:
            begin
                s3_z_next = s2_z_reg;
            end
            MODE_CART:
            begin
                if (s2_z_reg < 0)
                    s3_z_next = s2_z_reg + ANG_TWO_PI;
                else if (s2_z_reg >= ANG_TWO_PI)
                    s3_z_next = s2_z_reg - ANG_TWO_PI;
                else
                    s3_z_next = s2_z_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_v_reg)
        begin
            s3_ctl_reg <= s3_ctl_next;
            s3_x_reg   <= s3_x_next;
            s3_y_reg   <= s3_y_next;
            s3_z_reg   <= s3_z_next;
        end
    end

    // stage 4: fold the angle into [-pi/2, pi/2]
    always_comb
    begin
        s4_ctl_next = s3_ctl_reg;
        s4_z_next   = ANG_W'(s3_z_reg);
        if (s3_ctl_reg.mode == MODE_CART)
        begin
            priority if (s3_z_reg <= ANG_HALF_PI)
            begin
                s4_z_next       = ANG_W'(s3_z_reg);
                s4_ctl_next.aux = 1'b0;
            end
            else if (s3_z_reg < ANG_THREE_HALF)
            begin
                s4_z_next       = ANG_W'(s3_z_reg - ANG_PI);
                s4_ctl_next.aux = 1'b1;
            end
            else
            begin
                s4_z_next       = ANG_W'(s3_z_reg - ANG_TWO_PI);
                s4_ctl_next.aux = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4 && s3_v_reg)
        begin
            s4_ctl_reg <= s4_ctl_next;
            s4_x_reg   <= s3_x_reg;
            s4_y_reg   <= s3_y_reg;
            s4_z_reg   <= s4_z_next;
        end
    end

    assign out_v   = s4_v_reg;
    assign out_ctl = s4_ctl_reg;
    assign out_x   = s4_x_reg;
    assign out_y   = s4_y_reg;
    assign out_z   = s4_z_reg;

`ifndef SYNTHESIS
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        s4_v_reg && (s4_ctl_reg.mode == MODE_CART) |->
        (s4_z_reg <= ANG_W'(ANG_HALF_PI)) && (s4_z_reg >= -ANG_W'(ANG_HALF_PI)))
        else $error("folded angle out of range");
`endif

endmodule

FILE: design/cpa_cell.sv
// One CORDIC micro-rotation cell of the chain.
module cpa_cell #(
    parameter int XW   = cpa_pkg::DEF_IN_WIDTH + cpa_pkg::X_EXTRA,
    parameter int STEP = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_v,
    output logic                             in_rdy,
    input  cpa_pkg::cpa_ctl_t                in_ctl,
    input  logic signed [XW-1:0]             in_x,
    input  logic signed [XW-1:0]             in_y,
    input  logic signed [cpa_pkg::ANG_W-1:0] in_z,
    output logic                             out_v,
    input  logic                             out_rdy,
    output cpa_pkg::cpa_ctl_t                out_ctl,
    output logic signed [XW-1:0]             out_x,
    output logic signed [XW-1:0]             out_y,
    output logic signed [cpa_pkg::ANG_W-1:0] out_z
);
    import cpa_pkg::*;

    logic                    v_reg;
    cpa_ctl_t                ctl_reg;
    logic signed [XW-1:0]    x_reg, y_reg, x_next, y_next, dx, dy;
    logic signed [ANG_W-1:0] z_reg, z_next, ang;
    logic                    rot_pos;

    assign in_rdy = !v_reg || out_rdy;

    always_comb
    begin
        dx      = in_y >>> STEP;
        dy      = in_x >>> STEP;
        ang     = atan_entry(STEP);
        // vectoring drives y toward zero, rotation drives z toward zero
        rot_pos = (in_ctl.mode == MODE_POLAR) ? in_y[XW-1] : !in_z[ANG_W-1];
        x_next  = in_x;
        y_next  = in_y;
        z_next  = in_z;
        unique case (in_ctl.mode)
            MODE_MUL, MODE_CONJ:
            begin
                x_next = in_x;
                y_next = in_y;
                z_next = in_z;
            end
            MODE_POLAR, MODE_CART:
            begin
                if (rot_pos)
                begin
                    x_next = in_x - dx;
                    y_next = in_y + dy;
                    z_next = in_z - ang;
                end
                else
                begin
                    x_next = in_x + dx;
                    y_next = in_y - dy;
                    z_next = in_z + ang;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_rdy)
            v_reg <= in_v;
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy && in_v)
        begin
            ctl_reg <= in_ctl;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
        end
    end

    assign out_v   = v_reg;
    assign out_ctl = ctl_reg;
    assign out_x   = x_reg;
    assign out_y   = y_reg;
    assign out_z   = z_reg;

endmodule

FILE: design/cpa_post.sv
// Back pipeline: gain compensation, rounding, saturation and output register.
module cpa_post #(
    parameter int XW = cpa_pkg::DEF_IN_WIDTH + cpa_pkg::X_EXTRA
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_v,
    output logic                             in_rdy,
    input  cpa_pkg::cpa_ctl_t                in_ctl,
    input  logic signed [XW-1:0]             in_x,
    input  logic signed [XW-1:0]             in_y,
    input  logic signed [cpa_pkg::ANG_W-1:0] in_z,
    output logic                             out_v,
    input  logic                             out_rdy,
    output logic signed [cpa_pkg::OUT_W-1:0] out_c0,
    output logic signed [cpa_pkg::OUT_W-1:0] out_c1
);
    import cpa_pkg::*;

    localparam int HALF_G = 1 << (GUARD_BITS - 1);
    localparam int MPW    = 51;

    logic adv1, adv2;

    logic                    p1_v_reg;
    cpa_ctl_t                p1_ctl_reg;
    logic signed [OUT_W-1:0] p1_c0_reg, p1_c1_reg, p1_c0_next, p1_c1_next;
    logic [MPW-1:0]          p1_mp_reg, p1_mp_next;
    logic                    p1_big_reg, p1_big_next;
    logic signed [63:0]      xe;
    logic signed [XW-1:0]    xf, yf, xr, yr;
    logic signed [ANG_W-1:0] zr;

    logic                    p2_v_reg;
    logic [1:0]              p2_mode_reg;
    logic signed [OUT_W-1:0] p2_c0_reg, p2_c1_reg, p2_c0_next, p2_c1_next;
    logic [21:0]             mr;

    assign adv2   = !p2_v_reg || out_rdy;
    assign adv1   = !p1_v_reg || adv2;
    assign in_rdy = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end
        else
        begin
            if (adv1) p1_v_reg <= in_v;
            if (adv2) p2_v_reg <= p1_v_reg;
        end
    end

    always_comb
    begin
        xe          = 64'(in_x);
        p1_big_next = xe >= 64'sd536870912;
        p1_mp_next  = MPW'(xe[28:0]) * MPW'($unsigned(GAIN_Q22));
        xf          = in_ctl.aux ? -in_x : in_x;
        yf          = in_ctl.aux ? -in_y : in_y;
        xr          = (xf + XW'(HALF_G)) >>> GUARD_BITS;
        yr          = (yf + XW'(HALF_G)) >>> GUARD_BITS;
        zr          = (in_z + ANG_W'(131072)) >>> 18;
        p1_c0_next  = OUT_W'(in_x);
        p1_c1_next  = OUT_W'(in_y);
        unique case (in_ctl.mode)
            MODE_MUL, MODE_CONJ:
            begin
                p1_c0_next = OUT_W'(in_x);
                p1_c1_next = OUT_W'(in_y);
            end
            MODE_POLAR:
            begin
                p1_c0_next = '0;
                p1_c1_next = sat_out(64'(zr));
            end
            MODE_CART:
            begin
                p1_c0_next = sat_out(64'(xr));
                p1_c1_next = sat_out(64'(yr));
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_v)
        begin
            p1_ctl_reg <= in_ctl;
            p1_c0_reg  <= p1_c0_next;
            p1_c1_reg  <= p1_c1_next;
            p1_mp_reg  <= p1_mp_next;
            p1_big_reg <= p1_big_next;
        end
    end

    always_comb
    begin
        mr         = 22'((p1_mp_reg + MPW'(1 << 29)) >> 30);
        p2_c0_next = p1_c0_reg;
        p2_c1_next = p1_c1_reg;
        if (p1_ctl_reg.mode == MODE_POLAR)
        begin
            priority if (p1_ctl_reg.aux)
            begin
                p2_c0_next = '0;
                p2_c1_next = '0;
            end
            else if (p1_big_reg || (mr > 22'(OUT_MAX)))
                p2_c0_next = OUT_MAX;
            else
                p2_c0_next = OUT_W'(mr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && p1_v_reg)
        begin
            p2_mode_reg <= p1_ctl_reg.mode;
            p2_c0_reg   <= p2_c0_next;
            p2_c1_reg   <= p2_c1_next;
        end
    end

    assign out_v  = p2_v_reg;
    assign out_c0 = p2_c0_reg;
    assign out_c1 = p2_c1_reg;

`ifndef SYNTHESIS
    a_mag_sign: assert property (@(posedge clk) disable iff (!rst_n)
        p2_v_reg && (p2_mode_reg == MODE_POLAR) |-> !p2_c0_reg[OUT_W-1])
        else $error("negative magnitude");
`endif

endmodule

FILE: design/complex_pixel_arith_unit.sv
// Top level of the complex pixel arithmetic unit: config register and processing chain.
//
// Streams complex samples through a fixed operation chosen by op_mode: multiply a by b,
// conjugate a, cartesian to polar, or polar to cartesian. Inputs are Q3.12 (IN_WIDTH
// bits), results Q7.12, rounded half up and saturated to 20 bits. Every sample walks
// the same pipeline: four front stages (multiplies, angle reduction modulo 2*pi,
// CORDIC start values), a row of CORDIC_STEPS cells (one micro-rotation each), and two
// back stages (gain compensation, rounding, output register). One sample is accepted
// and one result delivered every cycle while result_stall is low, set by the
// one-rotation-per-cell chain. Each stage holds its transaction and advances when the
// next stage is empty or moving, so bubbles close up while a result is stalled at the
// output; sample_stall rises only once every stage is full.
// Write op_mode only while the pipeline is empty; each transaction carries its mode.
module complex_pixel_arith_unit #(
    parameter int CORDIC_STEPS = cpa_pkg::DEF_CORDIC_STEPS,
    parameter int IN_WIDTH     = cpa_pkg::DEF_IN_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  logic signed [IN_WIDTH-1:0]       a_first,
    input  logic signed [IN_WIDTH-1:0]       a_second,
    input  logic signed [IN_WIDTH-1:0]       b_real,
    input  logic signed [IN_WIDTH-1:0]       b_imag,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic signed [cpa_pkg::OUT_W-1:0] c_first,
    output logic signed [cpa_pkg::OUT_W-1:0] c_second
);
    import cpa_pkg::*;

    localparam int XW = IN_WIDTH + X_EXTRA;
    localparam int N  = CORDIC_STEPS;

    logic [1:0] op_mode_reg;
    logic       cfg_idx;
    logic       in_rdy;

    // chain taps: index 0 is the front pipeline output, index N feeds the back end
    logic                    ch_v   [N+1];
    logic                    ch_rdy [N+1];
    cpa_ctl_t                ch_ctl [N+1];
    logic signed [XW-1:0]    ch_x   [N+1];
    logic signed [XW-1:0]    ch_y   [N+1];
    logic signed [ANG_W-1:0] ch_z   [N+1];

    // Register file: one mode register, pready tied high
    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_mode_reg <= MODE_MUL;
        else if (psel && penable && pwrite && (cfg_idx == REG_OP_MODE))
            op_mode_reg <= pwdata[1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_idx == REG_OP_MODE)
            prdata = {30'b0, op_mode_reg};
    end

    cpa_pre #(
        .IN_WIDTH (IN_WIDTH),
        .XW       (XW)
    ) u_pre (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (op_mode_reg),
        .in_v     (sample_valid),
        .in_rdy   (in_rdy),
        .a_first  (a_first),
        .a_second (a_second),
        .b_real   (b_real),
        .b_imag   (b_imag),
        .out_v    (ch_v[0]),
        .out_rdy  (ch_rdy[0]),
        .out_ctl  (ch_ctl[0]),
        .out_x    (ch_x[0]),
        .out_y    (ch_y[0]),
        .out_z    (ch_z[0])
    );

    assign sample_stall = !in_rdy;

    // One micro-rotation per cell; cell k shifts by k
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        cpa_cell #(
            .XW   (XW),
            .STEP (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_v    (ch_v[k]),
            .in_rdy  (ch_rdy[k]),
            .in_ctl  (ch_ctl[k]),
            .in_x    (ch_x[k]),
            .in_y    (ch_y[k]),
            .in_z    (ch_z[k]),
            .out_v   (ch_v[k+1]),
            .out_rdy (ch_rdy[k+1]),
            .out_ctl (ch_ctl[k+1]),
            .out_x   (ch_x[k+1]),
            .out_y   (ch_y[k+1]),
            .out_z   (ch_z[k+1])
        );
    end

    cpa_post #(
        .XW (XW)
    ) u_post (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_v    (ch_v[N]),
        .in_rdy  (ch_rdy[N]),
        .in_ctl  (ch_ctl[N]),
        .in_x    (ch_x[N]),
        .in_y    (ch_y[N]),
        .in_z    (ch_z[N]),
        .out_v   (result_valid),
        .out_rdy (!result_stall),
        .out_c0  (c_first),
        .out_c1  (c_second)
    );

`ifndef SYNTHESIS
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
        else $error("input stalled while output can move");
`endif

endmodule
